>>> rtl/gbw_pkg.sv
// ----------------------------------------------------------------------------
// gbw_pkg: shared types and constants of the Gaussian blur window filter
// Register codes, item codes, datapath widths, controller states and the
// ring-row helper that maps an image row to a line-store row.
// ----------------------------------------------------------------------------
package gbw_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int RADIUS     = 4;
   localparam int TAPS       = 2 * RADIUS + 1;
   localparam int RING_ROWS  = 2 * RADIUS + 2;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int RING_W     = $clog2(RING_ROWS);
   localparam int ADDR_W     = RING_W + COL_W;
   localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;
   localparam int TAP_W      = $clog2(TAPS);
   localparam int ACC_T_W    = 47;
   localparam int ACC_S_W    = 39;
   localparam int NUM_W      = ACC_T_W + 2;
   localparam int DEN_W      = ACC_S_W + 1;

   typedef enum logic [2:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_BYPASS       = 3'd2,
      CSR_WEIGHT_0     = 3'd3,
      CSR_WEIGHT_1     = 3'd4,
      CSR_WEIGHT_2     = 3'd5,
      CSR_WEIGHT_3     = 3'd6,
      CSR_WEIGHT_4     = 3'd7
   } gbw_csr_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } gbw_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_DIV,
      ST_EMIT
   } gbw_state_type;

   typedef logic [RADIUS:0][15:0] gbw_weights_type;

   typedef struct packed {
      logic             start;
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
      logic [COL_W:0]   width;
      logic [ROW_W:0]   height;
   } gbw_tap_ctl_type;

   // Row modulo ten through a reciprocal multiply; exact below 16384.
   function automatic logic [RING_W-1:0] gbw_ring_row(input logic [ROW_W:0] row);
      logic [25:0]    prod;
      logic [9:0]     quot;
      logic [ROW_W:0] rem;
      prod = 26'(row) * 26'd6554;
      quot = prod[25:16];
      rem  = row - (ROW_W+1)'({quot, 3'b000}) - (ROW_W+1)'({quot, 1'b0});
      return rem[RING_W-1:0];
   endfunction

endpackage

>>> rtl/gbw_if.sv
// ----------------------------------------------------------------------------
// gbw channel interfaces
// Pixel request, blurred pixel response and register write channels.
// ----------------------------------------------------------------------------
interface gbw_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] pixel_in;
   modport source (output valid, op, pixel_in, input ready);
   modport sink   (input valid, op, pixel_in, output ready);
endinterface

interface gbw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       frame_end;
   modport source (output valid, pixel_out, frame_end, input ready);
   modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

interface gbw_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/gaussian_blur_window_filter.sv
// ----------------------------------------------------------------------------
// gaussian_blur_window_filter: streaming 9x9 Gaussian blur
// Raster-order 8-bit pixels in, blurred pixels out, with edge renormalization.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An item that completes no output window
// passes through accept, then window check; one that yields a blurred
// pixel then reads every tap of the 9x9 window through the single
// line-store read port, runs the multiply and accumulate pipeline and the
// bit-serial divider, and hands the result over. Bypass items go from
// accept straight to hand-over. The output register lets the next item
// enter while a result waits to be taken. No clearing pass runs after reset;
// line-store rows are read only after the current frame has written them.
// ----------------------------------------------------------------------------
module gaussian_blur_window_filter (
   input  logic       clock,
   input  logic       reset,
   gbw_req_if.sink    req_if,
   gbw_rsp_if.source  rsp_if,
   gbw_csr_if.sink    csr_if
);
   import gbw_pkg::*;

   // Configuration registers
   logic [10:0]     frame_width_ff;
   logic [12:0]     frame_height_ff;
   logic            bypass_ff;
   gbw_weights_type weights_ff;

   // Position counters and controller
   gbw_state_type    state_ff, state_in;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic             in_done_ff, in_done_in;
   logic [7:0]       pend_pix_ff, pend_pix_in;
   logic             pend_fe_ff, pend_fe_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_pix_ff, rsp_pix_in;
   logic             rsp_fe_ff, rsp_fe_in;

   logic [COL_W:0]   width, col_c, col_n, clast;
   logic [ROW_W:0]   height, row_c, row_n, rlast;
   logic             fire, last_px, complete;
   logic             wr_en, div_start, tap_done, div_done;
   gbw_tap_ctl_type  tap_ctl;
   logic [ACC_T_W-1:0] sum_t;
   logic [ACC_S_W-1:0] sum_s;
   logic [7:0]       quotient;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign fire = req_if.valid && req_if.ready;

   // Clamp the frame size to the supported range
   always_comb begin
      if (frame_width_ff == '0) begin
         width = 11'd1;
      end else if (frame_width_ff > 11'(MAX_WIDTH)) begin
         width = 11'(MAX_WIDTH);
      end else begin
         width = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         height = 13'd1;
      end else if (frame_height_ff > 13'(MAX_HEIGHT)) begin
         height = 13'(MAX_HEIGHT);
      end else begin
         height = frame_height_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd1024;
         frame_height_ff <= 13'd1024;
         bypass_ff       <= 1'b0;
         weights_ff[0]   <= 16'd32768;
         weights_ff[1]   <= 16'd19875;
         weights_ff[2]   <= 16'd4435;
         weights_ff[3]   <= 16'd364;
         weights_ff[4]   <= 16'd11;
      end else if (csr_if.valid) begin
         case (gbw_csr_type'(csr_if.index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_if.data[10:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_if.data[12:0];
            CSR_BYPASS:       bypass_ff       <= csr_if.data[0];
            CSR_WEIGHT_0:     weights_ff[0]   <= csr_if.data;
            CSR_WEIGHT_1:     weights_ff[1]   <= csr_if.data;
            CSR_WEIGHT_2:     weights_ff[2]   <= csr_if.data;
            CSR_WEIGHT_3:     weights_ff[3]   <= csr_if.data;
            CSR_WEIGHT_4:     weights_ff[4]   <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      in_done_in   = in_done_ff;
      pend_pix_in  = pend_pix_ff;
      pend_fe_in   = pend_fe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_fe_in    = rsp_fe_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      tap_ctl.start = 1'b0;

      // Clamp the input position for bypass, then step it
      col_c = ({1'b0, in_col_ff} >= width) ? width - 1'b1 : {1'b0, in_col_ff};
      row_c = ({1'b0, in_row_ff} >= height) ? height - 1'b1 : {1'b0, in_row_ff};
      if (!bypass_ff) begin
         col_c = {1'b0, in_col_ff};
         row_c = {1'b0, in_row_ff};
      end
      last_px = (col_c == width - 1'b1) && (row_c == height - 1'b1);
      col_n = col_c + 1'b1;
      row_n = row_c;
      if (col_n >= width) begin
         col_n = '0;
         row_n = row_c + 1'b1;
      end

      // Last row and column the current output window needs
      rlast = {1'b0, out_row_ff} + (ROW_W+1)'(RADIUS);
      if (rlast > height - 1'b1) begin
         rlast = height - 1'b1;
      end
      clast = {1'b0, out_col_ff} + (COL_W+1)'(RADIUS);
      if (clast > width - 1'b1) begin
         clast = width - 1'b1;
      end
      complete = in_done_ff || ({1'b0, in_row_ff} > rlast) ||
                 (({1'b0, in_row_ff} == rlast) && ({1'b0, in_col_ff} > clast));

      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               if (bypass_ff) begin
                  // Pass the pixel through and keep output in step with input
                  if (gbw_op_type'(req_if.op) == OP_PIXEL) begin
                     in_done_in  = 1'b0;
                     in_col_in   = col_n[COL_W-1:0];
                     in_row_in   = (row_n >= height) ? '0 : row_n[ROW_W-1:0];
                     out_col_in  = col_n[COL_W-1:0];
                     out_row_in  = (row_n >= height) ? '0 : row_n[ROW_W-1:0];
                     pend_pix_in = req_if.pixel_in;
                     pend_fe_in  = last_px;
                     state_in    = ST_EMIT;
                  end
               end else begin
                  // Store the pixel unless the frame is still flushing
                  if (gbw_op_type'(req_if.op) == OP_PIXEL && !in_done_ff) begin
                     wr_en     = 1'b1;
                     in_col_in = col_n[COL_W-1:0];
                     in_row_in = row_n[ROW_W-1:0];
                     if (row_n >= height) begin
                        in_row_in  = '0;
                        in_done_in = 1'b1;
                     end
                  end
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (complete) begin
               tap_ctl.start = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (tap_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               // Advance the output position; wrap ends the frame
               pend_pix_in = quotient;
               pend_fe_in  = 1'b0;
               if ({1'b0, out_col_ff} >= width - 1'b1) begin
                  out_col_in = '0;
                  if ({1'b0, out_row_ff} >= height - 1'b1) begin
                     out_row_in = '0;
                     pend_fe_in = 1'b1;
                     in_done_in = 1'b0;
                  end else begin
                     out_row_in = out_row_ff + 1'b1;
                  end
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold until the output register frees up
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = pend_pix_ff;
               rsp_fe_in    = pend_fe_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      tap_ctl.out_col = out_col_ff;
      tap_ctl.out_row = out_row_ff;
      tap_ctl.width   = width;
      tap_ctl.height  = height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         in_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         in_done_ff   <= in_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_pix_ff <= pend_pix_in;
      pend_fe_ff  <= pend_fe_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_fe_ff   <= rsp_fe_in;
   end

   gbw_tap_engine u_tap (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tap_ctl),
      .weights (weights_ff),
      .wr_en   (wr_en),
      .wr_addr ({gbw_ring_row({1'b0, in_row_ff}), in_col_ff}),
      .wr_data (req_if.pixel_in),
      .done    (tap_done),
      .sum_t   (sum_t),
      .sum_s   (sum_s)
   );

   gbw_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum_t    (sum_t),
      .sum_s    (sum_s),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.pixel_out = rsp_pix_ff;
   assign rsp_if.frame_end = rsp_fe_ff;

`ifndef SYNTHESIS
   a_tap_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      tap_done |-> state_ff == ST_SCAN)
      else $error("tap sum finished outside the scan state");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");
   a_eval_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> $past(fire) && !$past(bypass_ff))
      else $error("window check without an accepted item");
`endif

endmodule

>>> rtl/gbw_tap_engine.sv
// ----------------------------------------------------------------------------
// gbw_tap_engine: line store and weighted tap accumulator
// Holds the ring of image rows and walks the 9x9 window through its single
// read port, summing weight times pixel and the used weights.
// ----------------------------------------------------------------------------
module gbw_tap_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  gbw_pkg::gbw_tap_ctl_type            ctl,
   input  gbw_pkg::gbw_weights_type            weights,
   input  logic                                wr_en,
   input  logic [gbw_pkg::ADDR_W-1:0]          wr_addr,
   input  logic [7:0]                          wr_data,
   output logic                                done,
   output logic [gbw_pkg::ACC_T_W-1:0]         sum_t,
   output logic [gbw_pkg::ACC_S_W-1:0]         sum_s
);
   import gbw_pkg::*;

   logic [7:0] store [STORE_DEPTH];
   logic [7:0] rd_ff;

   logic             scan_ff, scan_in;
   logic [TAP_W-1:0] dy_ff, dy_in, dx_ff, dx_in;
   logic             v1_ff, l1_ff, l2_ff, done_ff;
   logic [31:0]      c1_ff, c2_ff;
   logic [39:0]      p2_ff;
   logic [ACC_T_W-1:0] t_ff, t_in;
   logic [ACC_S_W-1:0] s_ff, s_in;

   logic [ROW_W+1:0] tap_y;
   logic [COL_W+1:0] tap_x;
   logic             tap_ok, last_tap;
   logic [TAP_W-1:0] ady, adx;
   logic [31:0]      c0;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      tap_y = (ROW_W+2)'(ctl.out_row) + (ROW_W+2)'(dy_ff) - (ROW_W+2)'(RADIUS);
      tap_x = (COL_W+2)'(ctl.out_col) + (COL_W+2)'(dx_ff) - (COL_W+2)'(RADIUS);
      tap_ok = !tap_y[ROW_W+1] && (tap_y[ROW_W:0] < ctl.height) &&
               !tap_x[COL_W+1] && (tap_x[COL_W:0] < ctl.width);
      ady = (dy_ff >= TAP_W'(RADIUS)) ? dy_ff - TAP_W'(RADIUS) : TAP_W'(RADIUS) - dy_ff;
      adx = (dx_ff >= TAP_W'(RADIUS)) ? dx_ff - TAP_W'(RADIUS) : TAP_W'(RADIUS) - dx_ff;
      c0 = 32'(weights[ady[2:0]]) * 32'(weights[adx[2:0]]);
      rd_addr = {gbw_ring_row(tap_y[ROW_W:0]), tap_x[COL_W-1:0]};
      last_tap = scan_ff && (dx_ff == TAP_W'(TAPS - 1)) && (dy_ff == TAP_W'(TAPS - 1));

      scan_in = scan_ff;
      dy_in   = dy_ff;
      dx_in   = dx_ff;
      t_in    = t_ff + ACC_T_W'(p2_ff);
      s_in    = s_ff + ACC_S_W'(c2_ff);
      if (ctl.start) begin
         scan_in = 1'b1;
         dy_in   = '0;
         dx_in   = '0;
         t_in    = '0;
         s_in    = '0;
      end else if (scan_ff) begin
         if (dx_ff == TAP_W'(TAPS - 1)) begin
            dx_in = '0;
            if (dy_ff == TAP_W'(TAPS - 1)) begin
               scan_in = 1'b0;
            end else begin
               dy_in = dy_ff + 1'b1;
            end
         end else begin
            dx_in = dx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
         v1_ff   <= 1'b0;
         l1_ff   <= 1'b0;
         l2_ff   <= 1'b0;
         done_ff <= 1'b0;
         c2_ff   <= '0;
         p2_ff   <= '0;
      end else begin
         scan_ff <= scan_in;
         v1_ff   <= scan_ff && tap_ok;
         l1_ff   <= last_tap;
         l2_ff   <= l1_ff;
         done_ff <= l2_ff;
         c2_ff   <= v1_ff ? c1_ff : '0;
         p2_ff   <= v1_ff ? 40'(c1_ff) * 40'(rd_ff) : '0;
      end
      dy_ff <= dy_in;
      dx_ff <= dx_in;
      c1_ff <= c0;
      t_ff  <= t_in;
      s_ff  <= s_in;
   end

   assign done  = done_ff;
   assign sum_t = t_ff;
   assign sum_s = s_ff;

endmodule

>>> rtl/gbw_divider.sv
// ----------------------------------------------------------------------------
// gbw_divider: rounding weighted-mean divider
// Restoring division of (2t+s) by 2s, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbw_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gbw_pkg::ACC_T_W-1:0] sum_t,
   input  logic [gbw_pkg::ACC_S_W-1:0] sum_s,
   output logic                        done,
   output logic [7:0]                  quotient
);
   import gbw_pkg::*;

   logic             busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;
   logic [NUM_W-1:0] rem_ff, rem_in, shifted;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [2:0]       k_ff, k_in;
   logic [7:0]       q_ff, q_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      k_in    = k_ff;
      q_in    = q_ff;
      shifted = NUM_W'(den_ff) << k_ff;
      if (start) begin
         busy_in = 1'b1;
         zero_in = (sum_s == '0);
         rem_in  = (NUM_W'(sum_t) << 1) + NUM_W'(sum_s);
         den_in  = {sum_s, 1'b0};
         k_in    = 3'd7;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in   = rem_ff - shifted;
            q_in[k_ff] = 1'b1;
         end
         if (k_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      k_ff    <= k_in;
      q_ff    <= q_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? 8'd0 : q_ff;

endmodule

>>> dv/gaussian_blur_window_filter_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_blur_window_filter_chk: blur predictor and result checker
// Watches the register, pixel and result channels, keeps its own copy of the
// filter state and compares each taken result with the oldest expectation.
// ----------------------------------------------------------------------------
module gaussian_blur_window_filter_chk
   import gbw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gbw_req_if         req,
   gbw_rsp_if         rsp,
   gbw_csr_if         csr,
   output int         fail_count,
   output int         pending_count,
   output logic       flushing
);

   typedef struct {
      logic [7:0] pixel;
      logic       frame_end;
   } blur_result_type;

   blur_result_type   blur_expected[$];
   logic [10:0]       width_reg;
   logic [12:0]       height_reg;
   logic              bypass_reg;
   logic [15:0]       weight_reg [0:RADIUS];
   logic [7:0]        rows [0:RING_ROWS*MAX_WIDTH-1];
   int unsigned       in_col, in_row, out_col, out_row;
   logic              in_done;

   assign pending_count = blur_expected.size();
   assign flushing      = in_done && !bypass_reg;

   function automatic int unsigned eff_w();
      if (width_reg < 1) return 1;
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
   endfunction

   function automatic int unsigned eff_h();
      if (height_reg < 1) return 1;
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
   endfunction

   task automatic step_in(input int unsigned w, input int unsigned h);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
         if (in_row >= h) begin
            in_row  = 0;
            in_done = 1'b1;
         end
      end
   endtask

   function automatic logic [7:0] blur_pixel(input int unsigned w, input int unsigned h);
      logic [63:0] tsum, wsum, c;
      int          y, x;
      tsum = 0;
      wsum = 0;
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         y = int'(out_row) + dy;
         if (y < 0 || y >= int'(h)) continue;
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            x = int'(out_col) + dx;
            if (x < 0 || x >= int'(w)) continue;
            c = 64'(weight_reg[dy < 0 ? -dy : dy]) * 64'(weight_reg[dx < 0 ? -dx : dx]);
            tsum += c * rows[(y % RING_ROWS) * MAX_WIDTH + x];
            wsum += c;
         end
      end
      if (wsum == 0) return 8'd0;
      return 8'((2 * tsum + wsum) / (2 * wsum));
   endfunction

   // Advance the filter by one item; queue its result if it makes one.
   task automatic predict_item(input logic op, input logic [7:0] pix);
      int unsigned     w, h, rlast, clast;
      logic            last, done;
      blur_result_type r;
      w = eff_w();
      h = eff_h();
      if (bypass_reg) begin
         if (op == OP_DRAIN) return;
         if (in_col >= w) in_col = w - 1;
         if (in_row >= h) in_row = h - 1;
         last = (in_col == w - 1) && (in_row == h - 1);
         step_in(w, h);
         in_done = 1'b0;
         out_col = in_col;
         out_row = in_row;
         r.pixel = pix;
         r.frame_end = last;
         blur_expected.push_back(r);
         return;
      end
      if (op == OP_PIXEL && !in_done) begin
         rows[(in_row % RING_ROWS) * MAX_WIDTH + in_col] = pix;
         step_in(w, h);
      end
      rlast = out_row + RADIUS;
      clast = out_col + RADIUS;
      if (rlast > h - 1) rlast = h - 1;
      if (clast > w - 1) clast = w - 1;
      done = in_done || in_row > rlast || (in_row == rlast && in_col > clast);
      if (!done) return;
      r.pixel = blur_pixel(w, h);
      r.frame_end = 1'b0;
      if (out_col >= w - 1) begin
         out_col = 0;
         if (out_row >= h - 1) begin
            out_row = 0;
            r.frame_end = 1'b1;
            in_done = 1'b0;
         end else begin
            out_row++;
         end
      end else begin
         out_col++;
      end
      blur_expected.push_back(r);
   endtask

   always @(posedge clock) begin
      blur_result_type e;
      if (reset) begin
         width_reg  = 11'd1024;
         height_reg = 13'd1024;
         bypass_reg = 1'b0;
         weight_reg[0] = 16'd32768;
         weight_reg[1] = 16'd19875;
         weight_reg[2] = 16'd4435;
         weight_reg[3] = 16'd364;
         weight_reg[4] = 16'd11;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         in_done = 1'b0;
         fail_count = 0;
         blur_expected.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (gbw_csr_type'(csr.index))
               CSR_FRAME_WIDTH:  width_reg  = csr.data[10:0];
               CSR_FRAME_HEIGHT: height_reg = csr.data[12:0];
               CSR_BYPASS:       bypass_reg = csr.data[0];
               default:          weight_reg[csr.index - CSR_WEIGHT_0] = csr.data;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (blur_expected.size() == 0) begin
               $display("%0t: unexpected result pixel %0d frame_end %0b",
                        $time, rsp.pixel_out, rsp.frame_end);
               fail_count++;
            end else begin
               e = blur_expected.pop_front();
               if (rsp.pixel_out !== e.pixel) begin
                  $display("%0t: pixel_out expected %0d actual %0d",
                           $time, e.pixel, rsp.pixel_out);
                  fail_count++;
               end
               if (rsp.frame_end !== e.frame_end) begin
                  $display("%0t: frame_end expected %0b actual %0b",
                           $time, e.frame_end, rsp.frame_end);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) predict_item(req.op, req.pixel_in);
      end
   end

endmodule

>>> dv/gaussian_blur_window_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_blur_window_filter_tb: stimulus and verdict for the blur filter
// Runs directed frames, then random frames of random size, weights and bypass
// setting, under changing idle and stall patterns; a side checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module gaussian_blur_window_filter_tb;
   import gbw_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending_count;
   logic flushing;

   gbw_req_if req ();
   gbw_rsp_if rsp ();
   gbw_csr_if csr ();

   gaussian_blur_window_filter u_dut (
      .clock (clock), .reset (reset), .req_if (req), .rsp_if (rsp), .csr_if (csr)
   );

   gaussian_blur_window_filter_chk u_chk (
      .clock (clock), .reset (reset), .req (req), .rsp (rsp), .csr (csr),
      .fail_count (fail_count), .pending_count (pending_count), .flushing (flushing)
   );

   // Percent of cycles the sender idles and the receiver stalls.
   int   send_idle_pct;
   int   recv_stall_pct;
   logic hold_toggle;
   int   hold_left;
   // Ready levels sampled mid-cycle, so handshakes never race the edge.
   logic req_ready_seen;
   logic csr_ready_seen;
   int   random_items;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(negedge clock) begin
      req_ready_seen <= req.ready;
      csr_ready_seen <= csr.ready;
   end

   // Receiver: random stalls, plus a long hold-off whenever asked for.
   logic hold_seen;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_seen <= hold_toggle;
         hold_left <= 0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= 3000;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one item, idling first at random; return at the edge that takes it.
   task automatic send_item(input logic op, input logic [7:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.op       <= op;
      req.pixel_in <= pix;
      do @(posedge clock); while (!req_ready_seen);
   endtask

   task automatic write_reg(input gbw_csr_type idx, input logic [15:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr_ready_seen);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the sender until every expected result is out and the block is idle.
   task automatic wait_idle();
      req.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Run one whole frame: write every register, send the pixels with some
   // stray drains, then drain until the frame's outputs are all owed out.
   task automatic run_frame(input logic [10:0] w, input logic [12:0] h, input logic bp,
                            input int wmode, input int pixmode);
      int ew, eh;
      logic [7:0] pix;
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 16'(w));
      write_reg(CSR_FRAME_HEIGHT, 16'(h));
      write_reg(CSR_BYPASS, 16'(bp));
      for (int i = 0; i <= RADIUS; i++) begin
         case (wmode)
            0:       write_reg(gbw_csr_type'(CSR_WEIGHT_0 + i), pick_weight());
            1:       write_reg(gbw_csr_type'(CSR_WEIGHT_0 + i), 16'd0);
            default: write_reg(gbw_csr_type'(CSR_WEIGHT_0 + i), 16'd32768);
         endcase
      end
      ew = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      // A drain at frame start completes nothing.
      send_item(OP_DRAIN, pick_pixel());
      for (int n = 0; n < ew * eh; n++) begin
         if ($urandom_range(19) == 0) send_item(OP_DRAIN, pick_pixel());
         case (pixmode)
            1:       pix = 8'd255;
            2:       pix = (n % 2) ? 8'd255 : 8'd0;
            default: pix = pick_pixel();
         endcase
         send_item(OP_PIXEL, pix);
         random_items++;
      end
      // Flush; now and then offer a pixel, which the block drops as a drain.
      forever begin
         req.valid <= 1'b0;
         @(negedge clock);
         if (!flushing) break;
         send_item(($urandom_range(9) == 0) ? OP_PIXEL : OP_DRAIN, pick_pixel());
         random_items++;
      end
      if (bp) send_item(OP_DRAIN, pick_pixel());
      req.valid <= 1'b0;
   endtask

   initial begin
      int phase;
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.op         <= OP_PIXEL;
      req.pixel_in   <= 8'd0;
      csr.valid      <= 1'b0;
      csr.index      <= CSR_FRAME_WIDTH;
      csr.data       <= 16'd0;
      hold_toggle    = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_items   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: smallest frames, saturated pixels, zero and full weights.
      run_frame(11'd0, 13'd0, 1'b0, 0, 0);
      run_frame(11'd3, 13'd2, 1'b0, 2, 1);
      run_frame(11'd4, 13'd3, 1'b0, 1, 2);
      run_frame(11'd5, 13'd2, 1'b1, 0, 2);
      run_frame(11'd2, 13'd4, 1'b0, 0, 2);

      // Full-width clamp: wide frame blurred.
      run_frame(11'd2047, 13'd1, 1'b0, 0, 0);

      // Long receiver hold-off while the sender keeps offering items.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_toggle    = ~hold_toggle;
      run_frame(11'd10, 13'd10, 1'b0, 0, 0);

      phase = 0;
      while (random_items < 1450 || phase < 4) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         phase++;
         run_frame(11'($urandom_range(12, 1)), 13'($urandom_range(12, 1)),
                   ($urandom_range(4) == 0), 0, 0);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_idle();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("gaussian_blur_window_filter: match");
      else $display("gaussian_blur_window_filter: mismatch");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("gaussian_blur_window_filter: mismatch");
      $finish;
   end

endmodule
